// ===== rtl/core/nghri_pkg.sv =====
package nghri_pkg;

  localparam int MAX_HEADS_DEF  = 16;
  localparam int MAX_ORDER_DEF  = 8;
  localparam int TOKEN_BITS_DEF = 20;
  localparam int HIST_DEPTH     = 7;
  localparam int SEG_MAX        = 7;
  localparam logic [30:0] SIZE_MAX31 = 31'h7FFF_FFFF;

  // Item kinds
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_MULT  = 2'd1;
  localparam logic [1:0] KIND_SIZE  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_HEADS = 2'd1;
  localparam logic [1:0] REG_EOS   = 2'd2;

  // One head job handed from the front to the back.
  typedef struct packed {
    logic [63:0] mix;
    logic [3:0]  head;
    logic [30:0] size;
    logic        last;
  } job_t;

endpackage

// ===== rtl/core/nghri_ram.sv =====
module nghri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nghri_front.sv =====
module nghri_front import nghri_pkg::*; #(
  parameter int MAX_HEADS  = MAX_HEADS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [19:0] token,
  input  logic        first_in_sequence,
  input  logic [3:0]  table_index,
  input  logic [63:0] table_value,
  input  logic [3:0]  ngram_order,
  input  logic [4:0]  heads_per_order,
  input  logic [19:0] eos_token,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int TOKEN_BITS = TOKEN_BITS_DEF;
  localparam int OW = $clog2(MAX_ORDER);
  localparam int HW = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int HCW = $clog2(MAX_HEADS + 1);
  localparam int PW = TOKEN_BITS + 32;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_MHI  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_HRD  = 3'd5;
  localparam logic [2:0] ST_HEAD = 3'd6;

  logic [2:0]  state;
  logic [TOKEN_BITS-1:0] hist [HIST_DEPTH];
  logic [2:0]  seg_len;
  logic [TOKEN_BITS-1:0] vals [MAX_ORDER];
  logic [3:0]  order;
  logic [4:0]  heads;
  logic [OW:0] pos;
  logic [3:0]  gram;
  logic [4:0]  k;
  logic [HCW-1:0] head;
  logic [63:0] mix;
  logic [31:0] mul_b;
  logic [PW-1:0] mul_p;
  logic [PW-1:0] prod_lo;
  logic [31:0] prod_hi;
  logic [63:0] mult_rd;
  logic [31:0] size_rd;
  logic [TOKEN_BITS-1:0] tok;
  logic [TOKEN_BITS-1:0] eos;
  logic [2:0]  seg;
  logic [30:0] size_in;
  logic        tok_acc;
  logic        mult_we;
  logic        size_we;

  assign in_ready = (state == ST_IDLE);
  assign tok_acc  = in_valid && in_ready && (kind == KIND_TOKEN);
  assign tok = token[TOKEN_BITS-1:0];
  assign eos = eos_token[TOKEN_BITS-1:0];
  assign seg = first_in_sequence ? 3'd0 : seg_len;

  // Head size saturation on load.
  always_comb begin
    if (table_value[63] || table_value == 64'd0) begin
      size_in = 31'd0;
    end else if (table_value > {33'd0, SIZE_MAX31}) begin
      size_in = SIZE_MAX31;
    end else begin
      size_in = table_value[30:0];
    end
  end

  assign mult_we = in_valid && in_ready && (kind == KIND_MULT)
                   && ({1'b0, table_index} < 5'(MAX_ORDER));
  assign size_we = in_valid && in_ready && (kind == KIND_SIZE)
                   && ({3'b0, table_index} < 7'(MAX_HEADS));

  nghri_ram #(.WIDTH(64), .DEPTH(MAX_ORDER)) u_mult (
    .clk(clk), .we(mult_we), .waddr(table_index[OW-1:0]), .wdata(table_value),
    .raddr(pos[OW-1:0]), .rdata(mult_rd)
  );

  nghri_ram #(.WIDTH(32), .DEPTH(MAX_HEADS)) u_size (
    .clk(clk), .we(size_we), .waddr(table_index[HW-1:0]), .wdata({1'b0, size_in}),
    .raddr(head[HW-1:0]), .rdata(size_rd)
  );

  // Shared multiplier: token times the low, then the high half of the multiplier.
  assign mul_b = (state == ST_MHI) ? mult_rd[63:32] : mult_rd[31:0];
  assign mul_p = PW'(vals[pos[OW-1:0]]) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (state == ST_MLO) begin
      prod_lo <= mul_p;
    end
    if (state == ST_MHI) begin
      prod_hi <= mul_p[31:0];
    end
  end

  assign job_valid = (state == ST_HEAD);
  assign job.mix  = mix;
  assign job.head = 4'(head);
  assign job.size = size_rd[30:0];
  assign job.last = (k + 5'd1 >= heads && gram >= order)
                    || (32'(head) + 1 >= MAX_HEADS);

  // Sequencer: order 2 adds two products, each higher order one more; each order then runs its heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      seg_len <= 3'd0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (tok_acc) begin
            vals[0] <= tok;
            for (int s = 1; s < MAX_ORDER; s++) begin
              vals[s] <= (32'(seg) >= s && s - 1 < HIST_DEPTH) ? hist[s-1] : eos;
            end
            hist[0] <= tok;
            for (int i = 1; i < HIST_DEPTH; i++) begin
              hist[i] <= hist[i-1];
            end
            seg_len <= (tok == eos) ? 3'd0 : ((seg < 3'(SEG_MAX)) ? seg + 3'd1 : seg);
            order <= (ngram_order == 4'd0) ? 4'd1 :
                     ((32'(ngram_order) > MAX_ORDER) ? 4'(MAX_ORDER) : ngram_order);
            heads <= heads_per_order;
            mix   <= '0;
            pos   <= '0;
            gram  <= 4'd0;
            head  <= '0;
            if (heads_per_order != 5'd0 && ngram_order != 4'd1
                && ngram_order != 4'd0) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_MLO;
        end
        ST_MLO: begin
          state <= ST_MHI;
        end
        ST_MHI: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          mix  <= mix ^ (64'(prod_lo) + {prod_hi, 32'd0});
          pos  <= pos + 1'b1;
          gram <= gram + 4'd1;
          k    <= 5'd0;
          state <= (pos == '0) ? ST_MUL : ST_HRD;
        end
        ST_HRD: begin
          state <= ST_HEAD;
        end
        ST_HEAD: begin
          if (job_ready) begin
            head <= head + 1'b1;
            k    <= k + 5'd1;
            if (job.last) begin
              state <= ST_IDLE;
            end else if (k + 5'd1 >= heads) begin
              state <= ST_MUL;
            end else begin
              state <= ST_HRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && state == ST_HEAD && job_ready) begin
      assert (32'(head) < MAX_HEADS) else $error("head count past limit");
    end
  end

  a_mul_follows: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_MLO) else $error("multiply step skipped");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !in_ready) else $error("accepting during heads");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> 32'(head) < MAX_HEADS) else $error("head index overflow");

endmodule

// ===== rtl/core/nghri_back.sv =====
module nghri_back import nghri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // Two-entry queue between front and divider.
  job_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       busy;
  logic [5:0] step;
  logic       neg;
  logic [63:0] quo;
  logic [31:0] rem;
  logic [30:0] size;
  logic [3:0]  head;
  logic        last;
  logic        done;
  logic        take;
  logic [31:0] rsh;
  logic [32:0] dif;

  assign job_ready = (cnt != 2'd2);
  assign take = !busy && !done && cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      q[wp] <= job;
    end
  end

  assign rsh = {rem[30:0], quo[63]};
  assign dif = {1'b0, rsh} - {2'b0, size};

  // Restoring remainder divider, one dividend bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
      busy <= 1'b0; done <= 1'b0;
    end else begin
      wp <= wp ^ (job_valid && job_ready);
      rp <= rp ^ take;
      cnt <= cnt + 2'(job_valid && job_ready) - 2'(take);
      if (take) begin
        neg  <= q[rp].mix[63];
        quo  <= q[rp].mix[63] ? 64'd0 - q[rp].mix : q[rp].mix;
        size <= q[rp].size;
        head <= q[rp].head;
        last <= q[rp].last;
        rem  <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo  <= {quo[62:0], 1'b0};
        rem  <= dif[32] ? rsh : dif[31:0];
        step <= step + 6'd1;
        if (step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (done && m_axis_tready) begin
        done <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = done;
  assign m_axis_tlast  = last;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[3:0] = head;
    if (size == 31'd0) begin
      m_axis_tdata[34:4] = 31'd0;
    end else if (neg && rem != 32'd0) begin
      m_axis_tdata[34:4] = size - rem[30:0];
    end else begin
      m_axis_tdata[34:4] = rem[30:0];
    end
  end

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'd2) else $error("queue overflow");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(busy && done)) else $error("divider state clash");
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    done && size != 31'd0 |-> rem < {1'b0, size}) else $error("remainder too big");

endmodule

// ===== rtl/core/ngram_hash_row_index.sv =====
// Token beats: each n-gram term passes through the MUL, MLO, MHI and ACC states
// (two terms for order 2, one more per higher order), and each order's heads then go
// to the shared 64-step remainder unit. Up to MAX_HEADS heads per token (16 by
// default); the input waits until the last head is handed off.
// rst (synchronous) clears history, segment length and registers to defaults;
// table contents are undefined until loaded.
module ngram_hash_row_index import nghri_pkg::*; #(
  parameter int MAX_HEADS  = MAX_HEADS_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: token[19:0], table_index[23:20], table_value[87:24]
  input  logic [87:0] s_axis_tdata,
  // tuser: kind[1:0], first_in_sequence[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: head_index[3:0], row[34:4]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [3:0]  ngram_order;
  logic [4:0]  heads_per_order;
  logic [19:0] eos_token;
  logic        job_valid, job_ready;
  job_t        job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_order <= 4'd3;
      heads_per_order <= 5'd1;
      eos_token <= 20'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORDER: ngram_order <= cfg_data[3:0];
        REG_HEADS: heads_per_order <= cfg_data[4:0];
        REG_EOS:   eos_token <= cfg_data;
        default: ;
      endcase
    end
  end

  nghri_front #(.MAX_HEADS(MAX_HEADS), .MAX_ORDER(MAX_ORDER)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .kind(s_axis_tuser[1:0]), .token(s_axis_tdata[19:0]),
    .first_in_sequence(s_axis_tuser[2]), .table_index(s_axis_tdata[23:20]),
    .table_value(s_axis_tdata[87:24]), .ngram_order(ngram_order),
    .heads_per_order(heads_per_order), .eos_token(eos_token),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  nghri_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

endmodule
